// ----- rtl/assert_macros.svh -----
// assertion macros included by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// condition in one cycle requires the consequence in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// condition in one cycle requires the consequence in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/fsmf_pkg.sv -----
// shared types and constants of the first substring match finder
`default_nettype none
package fsmf_pkg;

   localparam int MAX_PATTERN_DEF = 16;
   localparam int MAX_TEXT_DEF    = 65536;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 5;
   localparam int POS_W       = 16;
   localparam int START_W     = 17;
   localparam int WIDE_W      = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int NEEDLE_MAX  = 16;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 24;

   localparam logic [START_W-1:0] START_NOT_FOUND = '1;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LENGTH = 2'd0,
      CSR_PATTERN_LOW    = 2'd1,
      CSR_PATTERN_HIGH   = 2'd2
   } csr_index_type;

   // one classified text beat handed from front to back
   typedef struct packed {
      logic             hit;
      logic [POS_W-1:0] pos;
      logic             last;
      logic             empty_needle;
   } entry_type;

   // queue fill status seen by the front and the back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage
`default_nettype wire

// ----- rtl/fsmf_front.sv -----
// front end: needle registers, text window, byte counter and window compare
`default_nettype none
module fsmf_front
   import fsmf_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF,
   parameter int MAX_TEXT    = MAX_TEXT_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tlast,
   input  wire queue_stat_type        q_stat,
   output logic                       push,
   output entry_type                  push_entry
);

   localparam int CNT_W = $clog2(MAX_TEXT + 1);

   logic [LEN_W-1:0]               len_ff;
   logic [NEEDLE_MAX*BYTE_W-1:0]   needle_ff;
   logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_ff, win_in, win_next;
   logic [CNT_W-1:0]               cnt_ff, cnt_in, cnt_next;
   logic                           active;
   logic                           accept;
   logic [MAX_PATTERN-1:0]         match_len;
   logic                           match_sel;
   logic                           len_ok;
   logic [WIDE_W-1:0]              pos_wide;

   assign req_tready = !q_stat.full;
   assign accept     = req_tvalid && req_tready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= '0;
         needle_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PATTERN_LENGTH: len_ff <= csr_wdata[LEN_W-1:0];
            CSR_PATTERN_LOW:    needle_ff[CSR_DATA_W-1:0] <= csr_wdata;
            CSR_PATTERN_HIGH:   needle_ff[2*CSR_DATA_W-1:CSR_DATA_W] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // window shift and counter, frozen once the text limit is reached
   assign active = cnt_ff < CNT_W'(MAX_TEXT);

   always_comb begin
      win_next = win_ff;
      cnt_next = cnt_ff;
      if (active) begin
         for (int k = MAX_PATTERN - 1; k > 0; k--) begin
            win_next[k] = win_ff[k-1];
         end
         win_next[0] = req_tdata[BYTE_W-1:0];
         cnt_next    = cnt_ff + CNT_W'(1);
      end
   end

   // per-length compare of the newest window bytes against the needle
   always_comb begin
      for (int l = 1; l <= MAX_PATTERN; l++) begin
         match_len[l-1] = 1'b1;
         for (int j = 0; j < l; j++) begin
            if (win_next[l-1-j] != needle_ff[j*BYTE_W +: BYTE_W]) begin
               match_len[l-1] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      match_sel = 1'b0;
      for (int l = 1; l <= MAX_PATTERN; l++) begin
         if (len_ff == LEN_W'(l)) begin
            match_sel = match_len[l-1];
         end
      end
   end

   assign len_ok   = (len_ff != '0) && (WIDE_W'(len_ff) <= WIDE_W'(MAX_PATTERN))
                     && (WIDE_W'(cnt_next) >= WIDE_W'(len_ff));
   assign pos_wide = WIDE_W'(cnt_next) - WIDE_W'(len_ff);

   // classified beat into the queue
   assign push = accept;
   always_comb begin
      push_entry.hit          = active && len_ok && match_sel;
      push_entry.pos          = pos_wide[POS_W-1:0];
      push_entry.last         = req_tlast;
      push_entry.empty_needle = (len_ff == '0);
   end

   // next window state, cleared after the last beat of a text
   always_comb begin
      win_in = win_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         if (req_tlast) begin
            win_in = '0;
            cnt_in = '0;
         end else begin
            win_in = win_next;
            cnt_in = cnt_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
         cnt_ff <= '0;
      end else begin
         win_ff <= win_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/fsmf_queue.sv -----
// short queue of classified beats between front and back
`default_nettype none
module fsmf_queue
   import fsmf_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   input  wire logic      pop,
   output entry_type      head_entry,
   output queue_stat_type q_stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign q_stat.full  = (count_ff == CNT_W'(DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign head_entry   = store_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/fsmf_back.sv -----
// back end: first hit tracking and the result output register
`default_nettype none
module fsmf_back
   import fsmf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire entry_type             head_entry,
   input  wire queue_stat_type        q_stat,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tuser
);

   logic             hit_ff, hit_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [START_W-1:0] start_ff, start_in;
   logic             found_ff, found_in;
   logic             hit_now;
   logic [POS_W-1:0] pos_now;

   // a last beat waits until the output register can take its result
   assign pop = !q_stat.empty && (!head_entry.last || !rsp_valid_ff || rsp_tready);

   // earliest hit wins
   assign hit_now = hit_ff || head_entry.hit;
   assign pos_now = hit_ff ? pos_ff : head_entry.pos;

   always_comb begin
      hit_in = hit_ff;
      pos_in = pos_ff;
      if (pop) begin
         if (head_entry.last) begin
            hit_in = 1'b0;
            pos_in = '0;
         end else begin
            hit_in = hit_now;
            pos_in = pos_now;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      start_in     = start_ff;
      found_in     = found_ff;
      if (pop && head_entry.last) begin
         rsp_valid_in = 1'b1;
         if (head_entry.empty_needle) begin
            start_in = '0;
            found_in = 1'b1;
         end else if (hit_now) begin
            start_in = START_W'(pos_now);
            found_in = 1'b1;
         end else begin
            start_in = START_NOT_FOUND;
            found_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff       <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hit_ff       <= hit_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      found_ff <= found_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(start_ff);
   assign rsp_tuser  = found_ff;

endmodule
`default_nettype wire

// ----- rtl/first_substring_match_finder.sv -----
// top level of the streaming first substring match finder
// Searches a byte stream for the first occurrence of a needle of up to MAX_PATTERN
// bytes held in the csr registers. One text byte is taken per req beat, one beat
// per cycle while req_tready is high; req_tlast marks the final byte of a text. The
// front compares the newest window bytes against the needle in the cycle a beat
// is accepted and writes the outcome into a QUEUE_DEPTH entry queue; the back
// takes one entry a cycle unless a last entry waits on a held result, and for the
// last byte loads the result register. req_tready drops only when the queue is
// full, which happens only while rsp_tready holds back a result. The result is
// the start index of the first match, or -1 with rsp_tuser low; an empty needle
// gives 0. Bytes past MAX_TEXT are dropped and never matched.
// Write the csr registers only while no text is in flight.
`default_nettype none
`include "assert_macros.svh"
module first_substring_match_finder
   import fsmf_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF,
   parameter int MAX_TEXT    = MAX_TEXT_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // text_byte
   input  wire logic                  req_tlast,  // text_end
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // match_start[16:0], zero pad
   output logic                       rsp_tuser   // match_found
);

   logic           push;
   entry_type      push_entry;
   logic           pop;
   entry_type      head_entry;
   queue_stat_type q_stat;

   // accept and classify text beats
   fsmf_front #(
      .MAX_PATTERN (MAX_PATTERN),
      .MAX_TEXT    (MAX_TEXT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_stat     (q_stat),
      .push       (push),
      .push_entry (push_entry)
   );

   // decoupling queue
   fsmf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_stat     (q_stat)
   );

   // hit tracking and result delivery
   fsmf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .q_stat     (q_stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // found flag agrees with the sign of the start index
   `ASSERT_IMPLY(a_found_sign, clock, reset, rsp_tvalid, rsp_tuser != rsp_tdata[START_W-1])
   // a miss reports exactly -1
   `ASSERT_IMPLY(a_miss_value, clock, reset, rsp_tvalid && !rsp_tuser,
                 rsp_tdata[START_W-1:0] == START_NOT_FOUND)
   // back pressure on input comes only from a full queue
   `ASSERT_ALWAYS(a_ready_full, clock, reset, req_tready == !q_stat.full)
   // a last entry is never dropped while a result is still waiting
   `ASSERT_NEXT(a_hold_last, clock, reset,
                !q_stat.empty && head_entry.last && rsp_tvalid && !rsp_tready,
                !q_stat.empty && head_entry.last)

endmodule
`default_nettype wire
